/* design/mdet_pkg.sv */
// Shared constants and types for the determinant unit.
package mdet_pkg;

    localparam int MaxOrder   = 4;
    localparam int EntryBits  = 12;
    localparam int StoreDepth = MaxOrder * MaxOrder;
    localparam int IdxBits    = $clog2(StoreDepth);
    localparam int CntBits    = $clog2(StoreDepth + 1);
    localparam int OrdBits    = 3;
    localparam int DetBits    = 50;
    // Fits exact determinant: 4 entries of 12 bits, 4! terms.
    localparam int AccBits    = 64;

    typedef logic signed [EntryBits-1:0] entry_t;
    typedef logic [OrdBits-1:0]          order_t;

    typedef struct packed {
        logic [1:0] perm_n;  // effective order minus one
    } job_t;

endpackage

/* design/mdet_front.sv */
// Input side: entry counting, entry store writes, job queue.
module mdet_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mdet_pkg::order_t       cfg_order,
    input  logic                   cfg_we,
    input  logic                   push,
    input  mdet_pkg::entry_t       entry_value,
    output logic                   full,
    output logic                   wr_en,
    output logic [mdet_pkg::IdxBits-1:0] wr_idx,
    output mdet_pkg::entry_t       wr_data,
    output logic                   job_valid,
    output mdet_pkg::job_t         job,
    input  logic                   job_take,
    input  logic                   back_busy
);
    import mdet_pkg::*;

    logic [CntBits-1:0] cnt_reg, cnt_next;
    logic               jv_reg;
    job_t               job_reg;
    logic [2:0]         n_eff;
    logic [CntBits-1:0] total;
    logic               accept, last;

    always_comb
    begin
        if (cfg_order == '0)
            n_eff = 3'd1;
        else if (cfg_order > 3'(MaxOrder))
            n_eff = 3'(MaxOrder);
        else
            n_eff = cfg_order;
        total = CntBits'(n_eff) * CntBits'(n_eff);
    end

    // The store is single-copy, so loading waits while a job is held or running.
    assign full    = jv_reg || back_busy;
    assign accept  = push && !full;
    assign last    = (cnt_reg + 1'b1) == total;
    assign wr_en   = accept;
    assign wr_idx  = cnt_reg[IdxBits-1:0];
    assign wr_data = entry_value;
    assign cnt_next = last ? '0 : cnt_reg + 1'b1;
    assign job_valid = jv_reg;
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            jv_reg  <= 1'b0;
            job_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                cnt_reg <= '0;
            else if (accept)
                cnt_reg <= cnt_next;
            if (accept && last)
            begin
                jv_reg         <= 1'b1;
                job_reg.perm_n <= 2'(n_eff - 3'd1);
            end
            else if (job_take)
                jv_reg <= 1'b0;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CntBits'(StoreDepth))
        else $error("entry count out of range");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        back_busy |-> !accept)
        else $error("entry accepted while engine busy");
    a_job_set: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> jv_reg)
        else $error("job lost");

endmodule

/* design/mdet_back.sv */
// Engine: Leibniz formula as a sum over up to 24 permutations, one product per step.
module mdet_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [mdet_pkg::IdxBits-1:0] wr_idx,
    input  mdet_pkg::entry_t       wr_data,
    input  logic                   job_valid,
    input  mdet_pkg::job_t         job,
    output logic                   job_take,
    output logic                   busy,
    output logic                   res_valid,
    output logic signed [mdet_pkg::DetBits-1:0] det_value,
    output logic                   overflow_flag,
    input  logic                   res_take
);
    import mdet_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_ACC, S_DONE} state_t;

    entry_t store [StoreDepth];
    state_t st_reg;
    logic [4:0] perm_reg;
    logic [1:0] nm1_reg;
    logic [2:0] k_reg;           // row being multiplied in
    logic signed [AccBits-1:0] prod_reg, acc_reg;
    entry_t rd_reg;
    logic rv_reg, ovf_reg;
    logic signed [DetBits-1:0] det_reg;
    logic [1:0] col;
    logic       parity;
    logic [4:0] nperm;
    logic signed [AccBits-1:0] sum;
    logic signed [51:0] mul_w;

    // Leading digit of the permutation index, that is the index divided by six.
    function automatic logic [1:0] plead(input logic [4:0] p);
        if (p >= 5'd18)
            return 2'd3;
        else if (p >= 5'd12)
            return 2'd2;
        else if (p >= 5'd6)
            return 2'd1;
        else
            return 2'd0;
    endfunction

    // Column of row k under permutation p of 0..3 (lexicographic).
    function automatic logic [1:0] pcol(input logic [4:0] p, input logic [1:0] k);
        logic [1:0] a [4];
        logic [1:0] r [4];
        logic [4:0] q;
        logic [1:0] i0, i1;
        logic [1:0] t;
        a[0] = 2'd0; a[1] = 2'd1; a[2] = 2'd2; a[3] = 2'd3;
        i0 = plead(p);
        q  = p - 5'(i0) * 5'd6;
        i1 = 2'(q >> 1);
        r[0] = a[i0];
        for (int j = 0; j < 3; j++)
            if (j >= int'(i0)) a[j] = a[j+1];
        r[1] = a[i1];
        for (int j = 0; j < 2; j++)
            if (j >= int'(i1)) a[j] = a[j+1];
        if (q[0]) begin t = a[0]; a[0] = a[1]; a[1] = t; end
        r[2] = a[0]; r[3] = a[1];
        return r[k];
    endfunction

    // The parity is the sum of the index digits: i0, q/2 and q%2.
    function automatic logic pparity(input logic [4:0] p);
        logic [1:0] i0;
        logic [4:0] q;
        i0 = plead(p);
        q  = p - 5'(i0) * 5'd6;
        return i0[0] ^ q[1] ^ q[0];
    endfunction

    assign col    = pcol(perm_reg, k_reg[1:0]);
    assign parity = pparity(perm_reg);
    assign sum    = parity ? acc_reg - prod_reg : acc_reg + prod_reg;
    assign mul_w  = $signed(prod_reg[39:0]) * rd_reg;
    // Permutations for order n are the first n! ones, which keep the top 4-n
    // positions in place; the rest is handled by offsetting row/col below.
    assign nperm  = (nm1_reg == 2'd0) ? 5'd1 : (nm1_reg == 2'd1) ? 5'd2 :
                    (nm1_reg == 2'd2) ? 5'd6 : 5'd24;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[wr_idx] <= wr_data;
    end

    // Order n uses the first n! permutations restricted to rows/cols 4-n..3,
    // remapped to 0..n-1: row r -> r-(4-n), col c -> c-(4-n).
    logic [1:0] off;
    logic [1:0] rrow, rcol;
    assign off  = 2'd3 - nm1_reg;
    assign rrow = k_reg[1:0] - off;
    assign rcol = col - off;
    logic [IdxBits-1:0] addr;
    always_comb
        addr = IdxBits'(({2'b0, rrow} * ({2'b0, nm1_reg} + 4'd1)) + {2'b0, rcol});

    always_ff @(posedge clk)
    begin
        if (st_reg == S_READ)
            rd_reg <= store[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            rv_reg  <= 1'b0;
            perm_reg <= '0;
            nm1_reg <= '0;
            k_reg   <= '0;
            prod_reg <= '0;
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            det_reg <= '0;
        end
        else
        begin
            if (res_take)
                rv_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (job_valid && !rv_reg)
                    begin
                        nm1_reg  <= job.perm_n;
                        perm_reg <= '0;
                        k_reg    <= 3'd3 - 3'(job.perm_n);
                        acc_reg  <= '0;
                        prod_reg <= AccBits'(1);
                        st_reg   <= S_READ;
                    end
                end
                S_READ:
                    st_reg <= S_MUL;
                S_MUL:
                begin
                    prod_reg <= AccBits'(mul_w);
                    if (k_reg == 3'd3)
                        st_reg <= S_ACC;
                    else
                    begin
                        k_reg  <= k_reg + 3'd1;
                        st_reg <= S_READ;
                    end
                end
                S_ACC:
                begin
                    acc_reg <= sum;
                    if (perm_reg == nperm - 5'd1)
                        st_reg <= S_DONE;
                    else
                    begin
                        perm_reg <= perm_reg + 5'd1;
                        k_reg    <= 3'd3 - 3'(nm1_reg);
                        prod_reg <= AccBits'(1);
                        st_reg   <= S_READ;
                    end
                end
                S_DONE:
                begin
                    rv_reg <= 1'b1;
                    if (acc_reg > AccBits'(64'sh1_FFFF_FFFF_FFFF))
                    begin
                        det_reg <= {1'b0, {(DetBits-1){1'b1}}};
                        ovf_reg <= 1'b1;
                    end
                    else if (acc_reg < -AccBits'(64'sh2_0000_0000_0000))
                    begin
                        det_reg <= {1'b1, {(DetBits-1){1'b0}}};
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        det_reg <= acc_reg[DetBits-1:0];
                        ovf_reg <= 1'b0;
                    end
                    st_reg <= S_IDLE;
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    // A finished result sits in its own register, so the store can be
    // reloaded while the result waits to be taken.
    assign job_take      = (st_reg == S_IDLE) && job_valid && !rv_reg;
    assign busy          = (st_reg != S_IDLE);
    assign res_valid     = rv_reg;
    assign det_value     = det_reg;
    assign overflow_flag = ovf_reg;

    a_perm: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> (perm_reg < nperm))
        else $error("permutation index out of window");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DONE) |=> rv_reg)
        else $error("result not posted");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> (st_reg == S_READ))
        else $error("job start missed");

endmodule

/* design/matrix_determinant_unit.sv */
// Top level of the streaming integer determinant unit.
// Once the last entry of an order-n matrix is accepted, the job is registered; the
// engine takes it when idle with no result waiting and posts the result from S_DONE.
// Throughput: one entry per cycle while full is low; per permutation the engine runs
// read and 40x12 multiply states per row and an accumulate state, input stalled.
// Reset is asynchronous and active low; it clears counts and the queue, sets order 4.
module matrix_determinant_unit
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  mdet_pkg::order_t        cfg_data,
    input  logic                    push,
    output logic                    full,
    input  mdet_pkg::entry_t        entry_value,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [mdet_pkg::DetBits-1:0] det_value,
    output logic                    overflow_flag
);
    import mdet_pkg::*;

    order_t order_reg;
    logic wr_en, job_valid, job_take, busy, res_valid;
    logic [IdxBits-1:0] wr_idx;
    entry_t wr_data;
    job_t   job;

    // The order register; writing it also restarts the matrix in progress.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= 3'(MaxOrder);
        else if (cfg_we)
            order_reg <= cfg_data;
    end

    mdet_front u_front
    (
        .clk(clk), .rst_n(rst_n), .cfg_order(order_reg), .cfg_we(cfg_we),
        .push(push), .entry_value(entry_value), .full(full),
        .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
        .job_valid(job_valid), .job(job), .job_take(job_take), .back_busy(busy)
    );

    mdet_back u_back
    (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
        .job_valid(job_valid), .job(job), .job_take(job_take), .busy(busy),
        .res_valid(res_valid), .det_value(det_value),
        .overflow_flag(overflow_flag), .res_take(pop && res_valid)
    );

    assign empty = !res_valid;

endmodule

/* test/testbench.sv */
// Testbench for the streaming integer determinant unit.
`timescale 1ns / 100ps

module testbench;
    import mdet_pkg::*;

    localparam int SettleWait  = 400;   // above the engine's worst-case latency
    localparam int HoldCycles  = 2000;
    localparam order_t OrderPlan[13] = '{3'd3, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6, 3'd0,
                                         3'd7, 3'd4, 3'd3, 3'd2, 3'd1, 3'd4};

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    order_t                  cfg_data;
    logic                    push;
    logic                    full;
    logic signed [11:0]      entry_value;
    logic                    empty;
    logic                    pop;
    logic signed [49:0]      det_value;
    logic                    overflow_flag;

    typedef struct {
        logic signed [49:0] det;
        logic               ovf;
    } det_result_t;

    entry_t       entry_feed[$];      // items waiting to be offered
    det_result_t  det_expected[$];    // determinants owed by the unit
    entry_t       matrix_copy[StoreDepth];
    int           entries_loaded;
    order_t       order_setting;
    int           mismatch_count;
    bit           no_idle;
    bit           hold_request;
    bit           hold_done;
    int           stall_left;

    matrix_determinant_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .entry_value   (entry_value),
        .empty         (empty),
        .pop           (pop),
        .det_value     (det_value),
        .overflow_flag (overflow_flag)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Order 0 behaves as order 1 and anything above the maximum as the maximum.
    function automatic int live_order();
        int n;
        n = int'(order_setting);
        if (n < 1)
            n = 1;
        if (n > MaxOrder)
            n = MaxOrder;
        return n;
    endfunction

    // Cofactor expansion along the top remaining row over the columns in mask.
    function automatic logic signed [127:0] minor_det(int row, int mask, int n);
        logic signed [127:0] sum;
        logic signed [127:0] term;
        logic signed [127:0] elem;
        int k;
        sum = 0;
        k = 0;
        if (row >= n)
            return 1;
        for (int c = 0; c < n; c++)
        begin
            if (mask[c])
            begin
                elem = matrix_copy[row * n + c];
                term = elem * minor_det(row + 1, mask & ~(1 << c), n);
                if (k[0])
                    sum = sum - term;
                else
                    sum = sum + term;
                k++;
            end
        end
        return sum;
    endfunction

    // Appends one item to the end of the feed.
    function automatic void feed(entry_t v);
        entry_feed = {entry_feed, v};
    endfunction

    // Records one accepted entry and owes a determinant once the matrix is complete.
    function automatic void take_entry(entry_t v);
        int n;
        logic signed [127:0] exact;
        det_result_t r;
        n = live_order();
        matrix_copy[entries_loaded] = v;
        entries_loaded++;
        if (entries_loaded == n * n)
        begin
            entries_loaded = 0;
            exact = minor_det(0, (1 << n) - 1, n);
            if (exact > 128'sd562949953421311)
            begin
                r.det = 50'sh1FFFFFFFFFFFF;
                r.ovf = 1'b1;
            end
            else if (exact < -128'sd562949953421312)
            begin
                r.det = 50'sh2000000000000;
                r.ovf = 1'b1;
            end
            else
            begin
                r.det = exact[49:0];
                r.ovf = 1'b0;
            end
            det_expected = {det_expected, r};
        end
    endfunction

    // Sender: an item leaves the feed only once the unit has taken it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                take_entry(entry_value);
                void'(entry_feed.pop_front());
            end
            if (entry_feed.size() > 0 && (no_idle || $urandom_range(99) >= 25))
            begin
                push <= 1'b1;
                entry_value <= entry_feed[0];
            end
            else
                push <= 1'b0;
        end
    end

    // Receiver: checks every accepted result against the oldest owed determinant.
    // A requested hold keeps pop low long enough for the unit to back up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (det_expected.size() == 0)
                begin
                    $error("unexpected result det_value=%0d", det_value);
                    mismatch_count++;
                end
                else
                begin
                    if (det_value !== det_expected[0].det)
                    begin
                        $error("det_value expected %0d actual %0d",
                               det_expected[0].det, det_value);
                        mismatch_count++;
                    end
                    if (overflow_flag !== det_expected[0].ovf)
                    begin
                        $error("overflow_flag expected %0d actual %0d",
                               det_expected[0].ovf, overflow_flag);
                        mismatch_count++;
                    end
                    void'(det_expected.pop_front());
                end
            end
            if (hold_request && !hold_done)
            begin
                stall_left = HoldCycles;
                hold_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
                pop <= no_idle || $urandom_range(99) >= 25;
        end
    end

    // Waits until every item is taken and every determinant has come back.
    task automatic drain();
        while (entry_feed.size() != 0 || det_expected.size() != 0)
            @(posedge clk);
    endtask

    // Writes the order only while the unit is idle; a write drops any partial matrix.
    task automatic set_order(order_t v);
        drain();
        repeat (SettleWait) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        order_setting = v;
        entries_loaded = 0;
    endtask

    function automatic entry_t pick_entry();
        case ($urandom_range(15))
            0: return -12'sd2048;
            1: return 12'sd2047;
            2: return 12'sd0;
            3: return -12'sd1;
            default: return entry_t'($urandom);
        endcase
    endfunction

    initial
    begin
        cfg_we = 1'b0;
        cfg_data = '0;
        push = 1'b0;
        pop = 1'b0;
        entry_value = '0;
        rst_n = 1'b0;
        mismatch_count = 0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        hold_done = 1'b0;
        stall_left = 0;
        entries_loaded = 0;
        order_setting = 3'd4;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Order 4 from reset: a diagonal of the most negative entry with one
        // positive extreme off the diagonal.
        for (int i = 0; i < 16; i++)
            feed((i % 5 == 0) ? -12'sd2048 : (i == 3 ? 12'sd2047 : 12'sd0));

        // Order zero acts as order 1, so every entry is its own determinant.
        set_order(3'd0);
        feed(-12'sd2048);
        feed(12'sd2047);
        feed(12'sd0);
        feed(-12'sd1);

        // An order above the maximum acts as the maximum; this partial matrix
        // must be thrown away by the next write.
        set_order(3'd7);
        feed(12'sd5);
        feed(-12'sd7);
        feed(12'sd9);

        set_order(3'd2);
        feed(12'sd2047);
        feed(-12'sd2048);
        feed(-12'sd2048);
        feed(12'sd2047);

        // Random phases across every order setting. The order-1 phase gives
        // one result per item, so a stalled receiver fills the unit fast.
        for (int p = 0; p < 13; p++)
        begin
            set_order(OrderPlan[p]);
            no_idle = (p == 8);
            hold_request = (p == 1);
            for (int i = 0; i < 130; i++)
                feed(pick_entry());
        end

        drain();
        repeat (SettleWait) @(posedge clk);
        if (mismatch_count == 0 && det_expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule
